>>> src/decimal_text_to_milli_parser_top_assert.svh
// assertion macros shared by the queue and back-end modules
// expects clk and rst_n in the scope of each use
`ifndef DECIMAL_TEXT_TO_MILLI_PARSER_TOP_ASSERT_SVH
`define DECIMAL_TEXT_TO_MILLI_PARSER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define DTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define DTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dtm_pkg.sv
// shared types, constants and helpers for the decimal text parser
// no dependencies
package dtm_pkg;

  localparam int MAX_CHARS_DEF        = 16;
  localparam int MAX_WHOLE_DIGITS_DEF = 6;

  localparam int WHOLE_W      = 20;
  localparam int FRAC_W       = 10;
  localparam int DCNT_W       = 3;
  localparam int MAG_W        = 30;
  localparam int VALUE_W      = 31;
  localparam int FRAC_DIGITS  = 3;
  localparam int MILLI_SCALE  = 1000;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_POINT,
    TK_MINUS,
    TK_BAD,
    TK_OVER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  // place value of the next fraction digit in thousandths
  function automatic logic [FRAC_W-1:0] frac_weight(input logic [DCNT_W-1:0] cnt);
    logic [FRAC_W-1:0] w;
    case (cnt)
      3'd0:    w = FRAC_W'(100);
      3'd1:    w = FRAC_W'(10);
      default: w = FRAC_W'(1);
    endcase
    return w;
  endfunction

endpackage

>>> src/dtm_front.sv
// front end: counts characters of a string and classifies each one into a token
// depends on dtm_pkg
module dtm_front #(
  parameter int MAX_CHARS = dtm_pkg::MAX_CHARS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] character
  input  logic            in_tlast,
  output logic            q_push,
  output dtm_pkg::token_t q_tok,
  input  logic            q_ready
);
  import dtm_pkg::*;

  localparam int CW = $clog2(MAX_CHARS + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          first;
  logic          over;

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;
  assign first     = (cnt_r == '0);
  assign over      = (cnt_r >= CW'(MAX_CHARS));

  always_comb begin
    q_tok.digit = in_tdata[3:0];
    q_tok.last  = in_tlast;
    if (over) begin
      q_tok.kind = TK_OVER;
    end else if (in_tdata == CH_MINUS && first) begin
      q_tok.kind = TK_MINUS;
    end else if (in_tdata == CH_POINT) begin
      q_tok.kind = TK_POINT;
    end else if (in_tdata inside {[CH_ZERO:CH_NINE]}) begin
      q_tok.kind = TK_DIGIT;
    end else begin
      q_tok.kind = TK_BAD;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_tlast) begin
        cnt_nxt = '0;
      end else if (!over) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/dtm_queue.sv
// short token queue between the front end and the back end
// depends on dtm_pkg
`include "decimal_text_to_milli_parser_top_assert.svh"
module dtm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dtm_pkg::token_t push_tok,
  output logic            ready,
  output logic            q_valid,
  output dtm_pkg::token_t q_tok,
  input  logic            pop
);
  import dtm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  token_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign ready   = (cnt_r != NW'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_tok   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `DTM_ASSERT_NOW(a_pop_nonempty, pop, cnt_r != '0, "queue popped while empty")
  `DTM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= NW'(QUEUE_DEPTH), "queue count beyond depth")
  `DTM_ASSERT_NOW(a_ptr_gap, cnt_r != NW'(QUEUE_DEPTH),
                  (wr_ptr_r - rd_ptr_r) == cnt_r[PW-1:0], "queue pointers disagree with count")

endmodule

>>> src/dtm_back.sv
// back end: applies tokens to the parse state, snapshots a finished string,
// scales it by 1000 into the output register; depends on dtm_pkg
`include "decimal_text_to_milli_parser_top_assert.svh"
module dtm_back #(
  parameter int MAX_WHOLE_DIGITS = dtm_pkg::MAX_WHOLE_DIGITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  dtm_pkg::token_t q_tok,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,  // [30:0] milli_value
  output logic            out_tuser   // [0] parse_ok
);
  import dtm_pkg::*;

  logic               neg_r, pt_r, err_r;
  logic [WHOLE_W-1:0] whole_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [DCNT_W-1:0]  wcnt_r, fcnt_r;

  logic               neg_n, pt_n, err_n;
  logic [WHOLE_W-1:0] whole_n;
  logic [FRAC_W-1:0]  frac_n;
  logic [DCNT_W-1:0]  wcnt_n, fcnt_n;

  logic               snap_valid_r;
  logic               snap_ok_r, snap_neg_r;
  logic [WHOLE_W-1:0] snap_whole_r;
  logic [FRAC_W-1:0]  snap_frac_r;
  logic               snap_adv;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_val_r;
  logic               out_ok_r;

  logic [MAG_W-1:0]   mag;
  logic [VALUE_W-1:0] val_nxt;

  assign snap_adv = snap_valid_r && (!out_valid_r || out_tready);
  // only a last token needs room in the snapshot
  assign q_pop    = q_valid && (!q_tok.last || !snap_valid_r || snap_adv);

  always_comb begin
    neg_n   = neg_r;
    pt_n    = pt_r;
    err_n   = err_r;
    whole_n = whole_r;
    frac_n  = frac_r;
    wcnt_n  = wcnt_r;
    fcnt_n  = fcnt_r;
    if (q_tok.kind == TK_OVER) begin
      err_n = 1'b1;
    end else if (!err_r) begin
      case (q_tok.kind)
        TK_DIGIT: begin
          if (!pt_r) begin
            if (wcnt_r >= DCNT_W'(MAX_WHOLE_DIGITS)) begin
              err_n = 1'b1;
            end else begin
              wcnt_n  = wcnt_r + DCNT_W'(1);
              whole_n = WHOLE_W'((whole_r << 3) + (whole_r << 1) + WHOLE_W'(q_tok.digit));
            end
          end else begin
            if (fcnt_r >= DCNT_W'(FRAC_DIGITS)) begin
              err_n = 1'b1;
            end else begin
              fcnt_n = fcnt_r + DCNT_W'(1);
              frac_n = frac_r + FRAC_W'(FRAC_W'(q_tok.digit) * frac_weight(fcnt_r));
            end
          end
        end
        TK_POINT: begin
          if (pt_r) begin
            err_n = 1'b1;
          end else begin
            pt_n = 1'b1;
          end
        end
        TK_MINUS: neg_n = 1'b1;
        default:  err_n = 1'b1;
      endcase
    end
  end

  assign mag     = MAG_W'(snap_whole_r * MAG_W'(MILLI_SCALE)) + MAG_W'(snap_frac_r);
  assign val_nxt = !snap_ok_r ? '0 :
                   snap_neg_r ? VALUE_W'(-{1'b0, mag}) : VALUE_W'({1'b0, mag});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r        <= 1'b0;
      pt_r         <= 1'b0;
      err_r        <= 1'b0;
      whole_r      <= '0;
      frac_r       <= '0;
      wcnt_r       <= '0;
      fcnt_r       <= '0;
      snap_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_tok.last) begin
          neg_r   <= 1'b0;
          pt_r    <= 1'b0;
          err_r   <= 1'b0;
          whole_r <= '0;
          frac_r  <= '0;
          wcnt_r  <= '0;
          fcnt_r  <= '0;
        end else begin
          neg_r   <= neg_n;
          pt_r    <= pt_n;
          err_r   <= err_n;
          whole_r <= whole_n;
          frac_r  <= frac_n;
          wcnt_r  <= wcnt_n;
          fcnt_r  <= fcnt_n;
        end
      end
      if (q_pop && q_tok.last) begin
        snap_valid_r <= 1'b1;
      end else if (snap_adv) begin
        snap_valid_r <= 1'b0;
      end
      if (snap_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop && q_tok.last) begin
      snap_ok_r    <= !err_n && (wcnt_n != '0) && !(pt_n && (fcnt_n == '0));
      snap_neg_r   <= neg_n;
      snap_whole_r <= whole_n;
      snap_frac_r  <= frac_n;
    end
    if (snap_adv) begin
      out_val_r <= val_nxt;
      out_ok_r  <= snap_ok_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_val_r};
  assign out_tuser  = out_ok_r;

  `DTM_ASSERT_NOW(a_bad_is_zero, out_valid_r && !out_ok_r, out_val_r == '0,
                  "failed parse with nonzero value")
  `DTM_ASSERT_NEXT(a_snap_hold, snap_valid_r && !snap_adv,
                   snap_valid_r && $stable(snap_whole_r) && $stable(snap_ok_r),
                   "stalled snapshot changed")
  `DTM_ASSERT_NEXT(a_clear_after_last, q_pop && q_tok.last,
                   wcnt_r == '0 && !err_r && !pt_r && !neg_r,
                   "parse state not cleared after string end")

endmodule

>>> src/decimal_text_to_milli_parser_top.sv
// channel  dir  tdata              tuser     tlast
// in_      in   [7:0] character    -         last_char
// out_     out  [30:0] milli_value [0] ok    -
//
// one character is taken per cycle while in_tready is high; the front classifies
// and counts, a four-entry token queue feeds the back end, which updates the parse
// state once per cycle while it pops tokens; after its last character a result
// passes the queue, the snapshot register and the scale-by-1000 output register
// reset clears counts, parse state and valid flags; no clearing pass is needed
// an output stall fills the snapshot, then the queue, then drops in_tready
// depends on dtm_pkg, dtm_front, dtm_queue, dtm_back
module decimal_text_to_milli_parser_top #(
  parameter int MAX_CHARS        = dtm_pkg::MAX_CHARS_DEF,
  parameter int MAX_WHOLE_DIGITS = dtm_pkg::MAX_WHOLE_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] milli_value, [31] zero
  output logic        out_tuser   // [0] parse_ok
);
  import dtm_pkg::*;

  logic   push, q_ready, q_valid, q_pop;
  token_t push_tok, head_tok;

  dtm_front #(.MAX_CHARS(MAX_CHARS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_push   (push),
    .q_tok    (push_tok),
    .q_ready  (q_ready)
  );

  dtm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_tok(push_tok),
    .ready   (q_ready),
    .q_valid (q_valid),
    .q_tok   (head_tok),
    .pop     (q_pop)
  );

  dtm_back #(.MAX_WHOLE_DIGITS(MAX_WHOLE_DIGITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_tok     (head_tok),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

>>> tb/sv/tb_top.sv
// self-checking bench for decimal_text_to_milli_parser_top: streams decimal text
// one character per item and checks every milli result against a typed answer
// or a built-in parser model; depends on dtm_pkg and the parser rtl
module tb_top;
  import dtm_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_CHARS   = 500;

  typedef struct packed {
    logic [VALUE_W-1:0] milli;
    logic               ok;
  } milli_result_t;

  // one entry per string: a hand-typed answer, or typed low to use the parser model
  typedef struct packed {
    logic          typed;
    milli_result_t res;
  } text_note_t;

  typedef struct {
    string text;
    bit    typed;
    int    val;
    bit    ok;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  int tx_idle_pct = 14;
  int rx_idle_pct = 48;
  int fail_count = 0;
  int stall_cycles = 0;

  milli_result_t  result_q[$];
  text_note_t     text_notes[$];
  dir_row_t       dir_rows[$];
  byte unsigned   text_buf[$];

  // parser model state
  logic [4:0]         m_count;
  logic               m_neg;
  logic               m_point;
  logic               m_err;
  logic [WHOLE_W-1:0] m_whole;
  logic [DCNT_W-1:0]  m_wdig;
  logic [FRAC_W-1:0]  m_frac;
  logic [DCNT_W-1:0]  m_fdig;

  decimal_text_to_milli_parser_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic void clear_text_state();
    m_count = '0;
    m_neg   = 1'b0;
    m_point = 1'b0;
    m_err   = 1'b0;
    m_whole = '0;
    m_wdig  = '0;
    m_frac  = '0;
    m_fdig  = '0;
  endfunction

  function automatic void take_char(input logic [7:0] ch);
    logic             first;
    logic [3:0]       dig;
    logic [FRAC_W-1:0] place;
    first = (m_count == 0);
    dig   = 4'(ch - CH_ZERO);
    if (m_count >= 5'(MAX_CHARS_DEF)) begin
      m_err = 1'b1;
    end else begin
      m_count = m_count + 5'd1;
      if (!m_err) begin
        if (ch == CH_MINUS && first) begin
          m_neg = 1'b1;
        end else if (ch == CH_POINT) begin
          if (m_point) m_err = 1'b1;
          else m_point = 1'b1;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
          if (!m_point) begin
            if (m_wdig >= DCNT_W'(MAX_WHOLE_DIGITS_DEF)) begin
              m_err = 1'b1;
            end else begin
              m_wdig  = m_wdig + 1'b1;
              m_whole = WHOLE_W'(m_whole * 10 + dig);
            end
          end else if (m_fdig >= DCNT_W'(FRAC_DIGITS)) begin
            m_err = 1'b1;
          end else begin
            // thousandths weight of this fraction position
            place  = (m_fdig == 0) ? FRAC_W'(100) : (m_fdig == 1) ? FRAC_W'(10) : FRAC_W'(1);
            m_fdig = m_fdig + 1'b1;
            m_frac = m_frac + FRAC_W'(dig) * place;
          end
        end else begin
          m_err = 1'b1;
        end
      end
    end
  endfunction

  function automatic milli_result_t close_text();
    milli_result_t    r;
    logic [MAG_W-1:0] mag;
    r.ok  = !m_err && m_wdig != 0 && !(m_point && m_fdig == 0);
    mag   = MAG_W'(m_whole) * MAG_W'(MILLI_SCALE) + MAG_W'(m_frac);
    if (!r.ok) r.milli = '0;
    else if (m_neg) r.milli = VALUE_W'(0) - {1'b0, mag};
    else r.milli = {1'b0, mag};
    clear_text_state();
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("tb_top: %s", msg);
  endtask

  // item bookkeeping and result checking on both channels
  always @(posedge clk) begin : scoreboard
    milli_result_t got;
    milli_result_t want;
    milli_result_t model;
    text_note_t    note;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        take_char(in_tdata);
        if (in_tlast) begin
          model = close_text();
          note  = text_notes.pop_front();
          result_q.push_back(note.typed ? note.res : model);
        end
      end
      if (out_tvalid && out_tready) begin
        got.milli = out_tdata[VALUE_W-1:0];
        got.ok    = out_tuser;
        if (result_q.size() == 0) begin
          note_failure($sformatf("unexpected result milli_value %0d parse_ok %0b",
                                 $signed(got.milli), got.ok));
        end else begin
          want = result_q.pop_front();
          if (got.milli !== want.milli)
            note_failure($sformatf("milli_value mismatch: expected %0d got %0d",
                                   $signed(want.milli), $signed(got.milli)));
          if (got.ok !== want.ok)
            note_failure($sformatf("parse_ok mismatch: expected %0b got %0b",
                                   want.ok, got.ok));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_char(input byte unsigned ch, input bit last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input bit typed, input milli_result_t res);
    text_note_t note;
    note.typed = typed;
    note.res   = res;
    text_notes.push_back(note);
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  // hold the sender off until every pending result is out
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0 || text_notes.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input string text, input bit typed, input int val, input bit ok);
    dir_row_t row;
    row.text  = text;
    row.typed = typed;
    row.val   = val;
    row.ok    = ok;
    dir_rows.push_back(row);
  endtask

  function automatic byte unsigned rand_digit();
    return CH_ZERO + byte'($urandom_range(0, 9));
  endfunction

  // mostly well-formed numbers; the rest broken in one of several ways
  task automatic make_text();
    int nw;
    int nf;
    int n;
    text_buf.delete();
    if ($urandom_range(0, 2) == 0) text_buf.push_back(CH_MINUS);
    nw = ($urandom_range(0, 3) == 0) ? MAX_WHOLE_DIGITS_DEF : $urandom_range(1, 6);
    for (int i = 0; i < nw; i++) text_buf.push_back(rand_digit());
    if ($urandom_range(0, 1) == 1) begin
      text_buf.push_back(CH_POINT);
      nf = $urandom_range(1, FRAC_DIGITS);
      for (int i = 0; i < nf; i++) text_buf.push_back(rand_digit());
    end
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 9))
        0: begin
          text_buf.delete();
          text_buf.push_back(CH_MINUS);
        end
        1: begin
          text_buf.delete();
          text_buf.push_back(CH_POINT);
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) text_buf.push_back(rand_digit());
        end
        2: text_buf.push_back(CH_POINT);
        3: begin
          text_buf.push_back(CH_POINT);
          text_buf.push_back(rand_digit());
        end
        4: begin
          text_buf.delete();
          n = $urandom_range(7, 9);
          for (int i = 0; i < n; i++) text_buf.push_back(rand_digit());
        end
        5: begin
          text_buf.delete();
          text_buf.push_back(rand_digit());
          text_buf.push_back(CH_POINT);
          for (int i = 0; i < 4; i++) text_buf.push_back(rand_digit());
        end
        6: text_buf.insert($urandom_range(1, text_buf.size()), CH_MINUS);
        7: text_buf.insert($urandom_range(0, text_buf.size()),
                           byte'($urandom_range(0, 255)));
        8: begin
          n = $urandom_range(17, 20);
          while (text_buf.size() < n) text_buf.push_back(rand_digit());
        end
        default: begin
          text_buf.delete();
          n = $urandom_range(1, 18);
          for (int i = 0; i < n; i++) text_buf.push_back(byte'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin : stimulus
    milli_result_t typed_res;
    milli_result_t none;
    int            phase_chars;
    int            strings_sent;
    none = '0;
    clear_text_state();

    // typed rows are obvious answers; the others go through the model
    add_row("0",                 1, 0,          1);
    add_row("999999.999",        1, 999999999,  1);
    add_row("-999999.999",       1, -999999999, 1);
    add_row("-0",                1, 0,          1);
    add_row("1.5",               1, 1500,       1);
    add_row("123.45",            0, 0,          0);
    add_row("-42",               0, 0,          0);
    add_row("7.007",             0, 0,          0);
    add_row("-000001.100",       0, 0,          0);
    add_row("-",                 1, 0,          0);
    add_row(".5",                1, 0,          0);
    add_row("12.",               1, 0,          0);
    add_row("1.2.3",             1, 0,          0);
    add_row("1234567",           1, 0,          0);
    add_row("1.2345",            1, 0,          0);
    add_row("1-2",               1, 0,          0);
    add_row("1a",                1, 0,          0);
    add_row("x99",               1, 0,          0);
    add_row("12345678901234567", 1, 0,          0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      text_buf.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++)
        text_buf.push_back(dir_rows[r].text[i]);
      typed_res.milli = VALUE_W'(dir_rows[r].val);
      typed_res.ok    = dir_rows[r].ok;
      send_text(dir_rows[r].typed, typed_res);
    end
    wait_results_drained();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 48 : 0;
      rx_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 14 : 0;
      phase_chars  = 0;
      strings_sent = 0;
      while (phase_chars < PHASE_CHARS) begin
        make_text();
        phase_chars += text_buf.size();
        send_text(1'b0, none);
        strings_sent++;
        if (strings_sent % 40 == 0) wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/dtm_pkg.sv
src/dtm_front.sv
src/dtm_queue.sv
src/dtm_back.sv
src/decimal_text_to_milli_parser_top.sv
tb/sv/tb_top.sv
